// File: rtl/core/gops_pkg.sv
package gops_pkg;

  // Width of the coordinate bits taken from each input word.
  localparam int unsigned CoordBits = 32;
  // Stored point width and emitted coordinate width (one extra fraction bit).
  localparam int unsigned PointBits = 32;
  localparam int unsigned OutBits   = PointBits + 1;
  // Largest number of results that one outline point can cause.
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntBits    = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    SegMove  = 3'd0,
    SegLine  = 3'd1,
    SegQuad  = 3'd2,
    SegCubic = 3'd3,
    SegClose = 3'd4
  } seg_code_e;

  typedef enum logic {
    KindCmd = 1'b0,
    KindXy  = 1'b1
  } item_kind_e;

  // One incoming outline point.
  typedef struct packed {
    logic [PointBits-1:0] x;
    logic [PointBits-1:0] y;
    logic                 on_curve;
    logic                 cubic_control;
    logic                 contour_end;
  } point_t;

  // One outgoing result word, without its last and error flags.
  typedef struct packed {
    item_kind_e                kind;
    seg_code_e                 code;
    logic signed [OutBits-1:0] x;
    logic signed [OutBits-1:0] y;
  } entry_t;

  // All results caused by one point, first result in entry 0.
  typedef struct packed {
    entry_t [MaxResults-1:0] ent;
    logic   [CntBits-1:0]    cnt;
    logic                    err;
  } bundle_t;

endpackage

// File: rtl/core/gops_tracker.sv
module gops_tracker import gops_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  point_t  pt_i,
  output bundle_t bun_o
);

  logic                 start_q, start_d;
  logic [1:0]           ptag_q, ptag_d;
  logic [1:0]           pend_q, pend_d;
  logic [PointBits-1:0] prev_x_q, prev_y_q;
  logic [PointBits-1:0] first_x_q, first_y_q, first_x_d, first_y_d;

  logic [PointBits-1:0]      px, py;
  logic signed [OutBits-1:0] px_w, py_w, prx_w, pry_w, fx_w, fy_w;
  logic [1:0]                tag;
  logic [1:0]                pend_mid;
  logic [CntBits-1:0]        n;
  logic                      err;
  entry_t                    cmd_e;

  // Sign-extend the used coordinate bits to the stored width.
  assign px = {{(PointBits-CoordBits+1){pt_i.x[CoordBits-1]}}, pt_i.x[CoordBits-2:0]};
  assign py = {{(PointBits-CoordBits+1){pt_i.y[CoordBits-1]}}, pt_i.y[CoordBits-2:0]};
  assign tag = {pt_i.cubic_control, pt_i.on_curve};

  assign px_w  = {px[PointBits-1], px};
  assign py_w  = {py[PointBits-1], py};
  assign prx_w = {prev_x_q[PointBits-1], prev_x_q};
  assign pry_w = {prev_y_q[PointBits-1], prev_y_q};

  // The contour's first point is this one when the contour starts here.
  assign first_x_d = start_q ? px : first_x_q;
  assign first_y_d = start_q ? py : first_y_q;
  assign fx_w = {first_x_d[PointBits-1], first_x_d};
  assign fy_w = {first_y_d[PointBits-1], first_y_d};

  // Build the result list for this point and the next state.
  always_comb begin
    bun_o = '0;
    n     = '0;
    err   = 1'b0;
    pend_mid = pend_q;
    cmd_e = '{kind: KindCmd, code: SegMove, x: '0, y: '0};

    if (start_q) begin
      err = ~tag[0];
      bun_o.ent[n] = cmd_e;
      n = n + 1'b1;
      pend_mid = 2'd0;
    end else if (tag[0]) begin
      if (ptag_q[0]) begin
        err = (pend_q != 2'd0);
        cmd_e.code = SegLine;
      end else if (ptag_q[1]) begin
        err = (pend_q != 2'd2);
        cmd_e.code = SegCubic;
      end else begin
        err = (pend_q != 2'd1);
        cmd_e.code = SegQuad;
      end
      bun_o.ent[n] = cmd_e;
      n = n + 1'b1;
      pend_mid = 2'd0;
    end else if (tag[1]) begin
      err = (ptag_q == 2'd0);
      if (pend_q != 2'd3) pend_mid = pend_q + 2'd1;
    end else if (!ptag_q[0]) begin
      // Two quadratic controls in a row: emit the implied on-curve midpoint.
      err = ptag_q[1] | (pend_q != 2'd1);
      cmd_e.code = SegQuad;
      bun_o.ent[n] = cmd_e;
      n = n + 1'b1;
      bun_o.ent[n] = '{kind: KindXy, code: SegMove, x: prx_w + px_w, y: pry_w + py_w};
      n = n + 1'b1;
      pend_mid = 2'd1;
    end else begin
      if (pend_q != 2'd3) pend_mid = pend_q + 2'd1;
    end

    // The point itself, doubled into the output scale.
    bun_o.ent[n] = '{kind: KindXy, code: SegMove, x: px_w <<< 1, y: py_w <<< 1};
    n = n + 1'b1;

    start_d = 1'b0;
    ptag_d  = tag;
    pend_d  = pend_mid;

    // Contour end: close any pending curve to the first point; emit a close.
    if (pt_i.contour_end) begin
      if (tag[0]) begin
        err = err | (pend_mid != 2'd0);
      end else begin
        cmd_e = '{kind: KindCmd, code: SegQuad, x: '0, y: '0};
        if (tag[1]) begin
          err = err | (pend_mid != 2'd2);
          cmd_e.code = SegCubic;
        end else begin
          err = err | (pend_mid != 2'd1);
        end
        bun_o.ent[n] = cmd_e;
        n = n + 1'b1;
        bun_o.ent[n] = '{kind: KindXy, code: SegMove, x: fx_w <<< 1, y: fy_w <<< 1};
        n = n + 1'b1;
      end
      bun_o.ent[n] = '{kind: KindCmd, code: SegClose, x: '0, y: '0};
      n = n + 1'b1;
      start_d = 1'b1;
      pend_d  = 2'd0;
      ptag_d  = 2'd0;
    end

    bun_o.cnt = n;
    bun_o.err = err;
  end

  // Outline state advances once per point handed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b1;
      ptag_q    <= 2'd0;
      pend_q    <= 2'd0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
    end else if (adv_i) begin
      start_q   <= start_d;
      ptag_q    <= ptag_d;
      pend_q    <= pend_d;
      prev_x_q  <= px;
      prev_y_q  <= py;
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
    end
  end

endmodule

// File: rtl/core/glyph_outline_to_path_segments.sv
// Glyph outline to path segments.
//
// The slave channel takes one outline point per word: tdata carries the 26.6
// x and y coordinates, tuser the on-curve and cubic-control tag bits, and
// tlast marks the last point of a contour. The master channel gives path
// commands and coordinate pairs (26.7) one word at a time; tlast marks the
// final word caused by an input point, and tuser carries the word kind and
// the tag-error flag.
//
// An accepted point passes the input register, the result bundle register
// and the output register before its first result word shows. A point that
// causes n words (one to six) sends them at one word per cycle while the
// receiver takes them, and the next point's words follow straight on. These
// registers part the channels, so a new point is taken while earlier words
// still wait. When the receiver stalls, the output and bundle hold and
// s_axis_tready drops once the input register is also full. Reset starts a
// fresh contour with all buffers empty.
module glyph_outline_to_path_segments import gops_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x[31:0], point_y[63:32]
  input  logic [1:0]  s_axis_tuser,   // on_curve[0], cubic_control[1]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // segment_code[2:0], coord_x[35:3],
                                      // coord_y[68:36], zero[71:69]
  output logic [1:0]  m_axis_tuser,   // item_kind[0], tag_error[1]
  output logic        m_axis_tlast
);

  logic    in_valid_q;
  point_t  in_q;
  logic    bun_valid_q;
  bundle_t bun_q;
  bundle_t bun_d;
  logic    out_valid_q;
  entry_t  out_q;
  logic    out_last_q, out_err_q;
  logic    move, load, bun_last;

  // One word leaves the bundle when the output register is free or draining.
  assign bun_last = (bun_q.cnt == CntBits'(1));
  assign move     = bun_valid_q & (~out_valid_q | m_axis_tready);
  assign load     = in_valid_q & (~bun_valid_q | (move & bun_last));
  assign s_axis_tready = ~in_valid_q | load;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.x             <= s_axis_tdata[31:0];
      in_q.y             <= s_axis_tdata[63:32];
      in_q.on_curve      <= s_axis_tuser[0];
      in_q.cubic_control <= s_axis_tuser[1];
      in_q.contour_end   <= s_axis_tlast;
    end
  end

  // Outline state and result list for the point in the input register.
  gops_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (load),
    .pt_i   (in_q),
    .bun_o  (bun_d)
  );

  // Result bundle: shifts down by one word per move.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bun_valid_q <= 1'b0;
    end else if (load) begin
      bun_valid_q <= 1'b1;
    end else if (move && bun_last) begin
      bun_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bun_q <= bun_d;
    end else if (move) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        bun_q.ent[i] <= bun_q.ent[i+1];
      end
      bun_q.cnt <= bun_q.cnt - CntBits'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q      <= bun_q.ent[0];
      out_last_q <= bun_last;
      out_err_q  <= bun_q.err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.y, out_q.x, out_q.code};
  assign m_axis_tuser  = {out_err_q, out_q.kind};
  assign m_axis_tlast  = out_last_q;

  // A held bundle always carries between one and six words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bun_valid_q |-> (bun_q.cnt != '0) && (bun_q.cnt <= CntBits'(MaxResults)))
    else $error("bundle word count out of range");

  // A point waiting in the input register is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !load) |=> in_valid_q)
    else $error("input point lost");

  // A word moved out of the bundle shows on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("moved word not presented");

  // Without a move the bundle keeps its words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bun_valid_q && !move) |=> bun_valid_q && $stable(bun_q.cnt))
    else $error("bundle changed without a move");

endmodule
